@@ sv/iss_pkg.sv @@
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types, widths and codes for the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 64;
    localparam int ST_W   = 2;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [CW-1:0]     t_count;
    typedef logic [AW-1:0]     t_addr;

    localparam t_kind K_APPEND = 3'd0;
    localparam t_kind K_REMOVE = 3'd1;
    localparam t_kind K_READ   = 3'd2;
    localparam t_kind K_NEXT   = 3'd3;
    localparam t_kind K_PREV   = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    typedef struct packed {
        t_value  read_value;
        t_status status;
        t_count  length;
        t_addr   cursor;
    } t_result;

endpackage

@@ sv/iss_in_if.sv @@
// ----------------------------------------------------------------------------
// iss_in_if
// Command channel: operation kind, index and append value.
// ----------------------------------------------------------------------------
interface iss_in_if;
    logic            valid;
    logic            ready;
    iss_pkg::t_kind  kind;
    iss_pkg::t_index index;
    iss_pkg::t_value value;

    modport source (output valid, output kind, output index, output value, input ready);
    modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

@@ sv/iss_out_if.sv @@
// ----------------------------------------------------------------------------
// iss_out_if
// Result channel: read value, status, length and cursor.
// ----------------------------------------------------------------------------
interface iss_out_if;
    logic             valid;
    logic             ready;
    iss_pkg::t_value  read_value;
    iss_pkg::t_status status;
    iss_pkg::t_count  length;
    iss_pkg::t_addr   cursor;

    modport source (output valid, output read_value, output status, output length,
                    output cursor, input ready);
    modport sink   (input valid, input read_value, input status, input length,
                    input cursor, output ready);
endinterface

@@ sv/iss_ram.sv @@
// ----------------------------------------------------------------------------
// iss_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iss_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  iss_pkg::t_addr  i_waddr,
    input  iss_pkg::t_value i_wdata,
    input  iss_pkg::t_addr  i_raddr,
    output iss_pkg::t_value o_rdata
);

    iss_pkg::t_value r_mem [iss_pkg::DEPTH];
    iss_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/iss_ctrl.sv @@
// ----------------------------------------------------------------------------
// iss_ctrl
// Operation sequencer: holds length and cursor, drives the entry memory and
// walks the tail down one entry per cycle on a remove.
// ----------------------------------------------------------------------------
module iss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    iss_in_if.sink           i_in,
    input  logic             i_slot_free,
    output logic             o_push,
    output iss_pkg::t_result o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    iss_pkg::t_count  r_count, n_count;
    iss_pkg::t_addr   r_cursor, n_cursor;
    iss_pkg::t_addr   r_ptr, n_ptr;
    iss_pkg::t_value  r_value, n_value;
    iss_pkg::t_status r_status, n_status;
    iss_pkg::t_kind   r_kind;
    iss_pkg::t_index  r_idx;
    iss_pkg::t_value  r_in_value;

    logic             w_accept;
    logic             w_we;
    iss_pkg::t_addr   w_waddr;
    iss_pkg::t_value  w_wdata;
    iss_pkg::t_addr   w_raddr;
    iss_pkg::t_value  w_rdata;

    logic             w_empty;
    logic             w_idx_ge;
    logic             w_stale;
    iss_pkg::t_addr   w_cur_eff;
    iss_pkg::t_count  w_cur_p1;
    iss_pkg::t_count  w_count_m1;
    iss_pkg::t_count  w_idx_p1;
    iss_pkg::t_count  w_ptr_p1;
    iss_pkg::t_addr   w_target;

    iss_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_empty    = (r_count == '0);
    assign w_idx_ge   = ({1'b0, r_idx} >= {{(iss_pkg::IDX_W + 1 - iss_pkg::CW){1'b0}}, r_count});
    assign w_stale    = ({1'b0, r_cursor} >= r_count);
    assign w_cur_eff  = w_stale ? '0 : r_cursor;
    assign w_cur_p1   = {1'b0, w_cur_eff} + iss_pkg::t_count'(1);
    assign w_count_m1 = r_count - iss_pkg::t_count'(1);
    assign w_idx_p1   = {1'b0, r_idx[iss_pkg::AW-1:0]} + iss_pkg::t_count'(1);
    assign w_ptr_p1   = {1'b0, r_ptr} + iss_pkg::t_count'(1);

    always_comb begin
        if (r_kind == iss_pkg::K_NEXT) begin
            w_target = (w_cur_p1 >= r_count) ? '0 : w_cur_p1[iss_pkg::AW-1:0];
        end else begin
            w_target = (w_cur_eff == '0) ? w_count_m1[iss_pkg::AW-1:0]
                                         : w_cur_eff - iss_pkg::t_addr'(1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_ptr    = r_ptr;
        n_value  = r_value;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_count[iss_pkg::AW-1:0];
        w_wdata  = r_in_value;
        w_raddr  = r_ptr;
        o_push   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_value  = '0;
                n_status = iss_pkg::ST_OK;
                n_state  = S_DONE;
                case (r_kind)
                    iss_pkg::K_APPEND: begin
                        if (r_count >= iss_pkg::t_count'(iss_pkg::DEPTH)) begin
                            n_status = iss_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + iss_pkg::t_count'(1);
                        end
                    end
                    iss_pkg::K_REMOVE: begin
                        if (w_empty) begin
                            n_status = iss_pkg::ST_EMPTY;
                        end else if (w_idx_ge) begin
                            n_status = iss_pkg::ST_RANGE;
                        end else begin
                            n_cursor = '0;
                            if (w_idx_p1 < r_count) begin
                                // start the tail walk: fetch the entry after the gap
                                w_raddr = w_idx_p1[iss_pkg::AW-1:0];
                                n_ptr   = w_idx_p1[iss_pkg::AW-1:0];
                                n_state = S_SHIFT;
                            end else begin
                                n_count = w_count_m1;
                            end
                        end
                    end
                    iss_pkg::K_READ: begin
                        if (w_stale) begin
                            n_cursor = '0;
                        end
                        if (w_empty) begin
                            n_status = iss_pkg::ST_EMPTY;
                        end else if (w_idx_ge) begin
                            n_status = iss_pkg::ST_RANGE;
                        end else begin
                            n_cursor = r_idx[iss_pkg::AW-1:0];
                            w_raddr  = r_idx[iss_pkg::AW-1:0];
                            n_state  = S_READ;
                        end
                    end
                    iss_pkg::K_NEXT, iss_pkg::K_PREV: begin
                        if (w_empty) begin
                            n_status = iss_pkg::ST_EMPTY;
                        end else begin
                            n_cursor = w_target;
                            w_raddr  = w_target;
                            n_state  = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                // move the fetched entry down one place, fetch the next
                w_we    = 1'b1;
                w_waddr = r_ptr - iss_pkg::t_addr'(1);
                w_wdata = w_rdata;
                if (w_ptr_p1 < r_count) begin
                    w_raddr = w_ptr_p1[iss_pkg::AW-1:0];
                    n_ptr   = w_ptr_p1[iss_pkg::AW-1:0];
                end else begin
                    n_count = w_count_m1;
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_value = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_status <= n_status;
        if (w_accept) begin
            r_kind     <= i_in.kind;
            r_idx      <= i_in.index;
            r_in_value <= i_in.value;
        end
    end

    assign o_res.read_value = r_value;
    assign o_res.status     = r_status;
    assign o_res.length     = r_count;
    assign o_res.cursor     = r_cursor;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iss_pkg::t_count'(iss_pkg::DEPTH))
        else $error("entry count above depth");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (({1'b0, r_cursor} < r_count) || (r_cursor == '0)))
        else $error("cursor outside the stored entries");

    a_shift_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (({1'b0, r_ptr} < r_count) && (r_ptr != '0)))
        else $error("tail walk pointer out of range");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

endmodule

@@ sv/indexed_sequence_store_with_cursor_core.sv @@
// ----------------------------------------------------------------------------
// indexed_sequence_store_with_cursor_core
// Ordered store of up to 64 entries of 64 bits with a cached cursor.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command word (kind, index, value): append, remove at
//   index, read at index, rotate next, rotate prev. Every command gives
//   exactly one word on o_out with read_value, status, length and cursor.
//   The block takes one command at a time. Append and the unused kinds go
//   from execute to the result register, read and rotate go via a memory
//   read state, and remove of any entry but the last walks the tail down
//   one entry per cycle through the single write port of the entry memory.
//   The next command is taken in the cycle after the result is registered.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, a finished result holds inside the
//   sequencer until the output register frees, and no further command is
//   taken. Reset (synchronous, active low) empties the store and sets the
//   cursor to 0; memory contents are not cleared since only entries below
//   the length are ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_store_with_cursor_core (
    input  logic i_clk,
    input  logic i_rst_n,
    iss_in_if.sink    i_in,
    iss_out_if.source o_out
);

    logic             r_out_valid;
    iss_pkg::t_result r_out;
    iss_pkg::t_result w_res;
    logic             w_push;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || o_out.ready;

    iss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (w_slot_free),
        .o_push      (w_push),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out.read_value;
    assign o_out.status     = r_out.status;
    assign o_out.length     = r_out.length;
    assign o_out.cursor     = r_out.cursor;

endmodule
